FILE: hw/rtl/gpc_pkg.sv
// Shared constants, register codes and control bundles for the grid palindrome counter.
package gpc_pkg;

    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_LEN_DEF  = 6;

    localparam int LETTER_W    = 8;
    localparam int PAL_LEN_W   = 3;
    localparam int GRID_COLS_W = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int PAL_COUNT_W = 23;
    localparam int FOUND_W     = 3;

    localparam logic [PAL_LEN_W-1:0]   PAL_LENGTH_RST = 3'd1;
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST  = 11'd1024;
    localparam logic [PAL_COUNT_W-1:0] PAL_COUNT_MAX  = 23'd4194304;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PAL_LENGTH = 1'b0,
        REG_GRID_COLS  = 1'b1
    } cfg_reg_t;

    // column store access for one cycle
    typedef struct packed {
        logic rd_en;
        logic rd_tail;
        logic wr_en;
        logic tail_wr;
    } store_ctrl_t;

    typedef struct packed {
        logic step;
        logic last;
        logic restart;
    } tally_ctrl_t;

endpackage

FILE: hw/rtl/grid_palindrome_counter_core.sv
// The cell marked last is registered in the cell stage; its count is then registered
// in the result output register, where it goes valid.
// Throughput: one cell per cycle; each cell makes one read of the column store
// (one history word per column), and each cell past column 0 writes the word for the column to its left.
// A pending count holds only a following cell marked last.
// Reset clears the position, row count, total and handshake state; the column store
// is not cleared, as every history it returns is guarded by the row and column counts.
module grid_palindrome_counter_core #(
    parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEF,
    parameter int MAX_LEN  = gpc_pkg::MAX_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] letter
    input  logic                              s_axis_tlast,   // last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,   // [22:0] pal_count
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gpc_pkg::GRID_COLS_W-1:0]   cfg_data
);

    localparam int BW   = gpc_pkg::LETTER_W;
    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNW  = $clog2(MAX_COLS + 1);
    localparam int LW   = $clog2(MAX_LEN + 1);
    localparam int KW   = CNW + LW + 1;
    localparam int RW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int HIST = (MAX_LEN > 1) ? MAX_LEN - 1 : 1;
    localparam int HW   = HIST * BW;
    localparam int SW   = MAX_LEN * BW;
    localparam int EW   = 3 * HW;

    // configuration
    logic [gpc_pkg::PAL_LEN_W-1:0]   pal_length_reg;
    logic [gpc_pkg::GRID_COLS_W-1:0] grid_cols_reg;
    logic                            cols_restart;
    logic [LW-1:0]                   len_eff;
    logic [CNW-1:0]                  cols_eff;

    // front end
    logic          in_acc;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] rows_reg;
    logic          col_last;

    // cell stage
    logic          s1_valid_reg;
    logic          s1_go;
    logic [BW-1:0] s1_letter_reg;
    logic          s1_last_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_rows_reg;
    logic          s1_lastcol_reg;

    logic [HW-1:0] h_reg;
    logic [HW-1:0] h_next;
    logic [HW-1:0] v_last_reg;
    logic [HW-1:0] d3_last_reg;
    logic [HW-1:0] d3_last2_reg;

    logic [EW-1:0] prev_word;
    logic [HW-1:0] pv;
    logic [HW-1:0] p2;
    logic [HW-1:0] p3;
    logic [HW-1:0] nv;
    logic [HW-1:0] nd2;
    logic [HW-1:0] nd3;
    logic [SW-1:0] seq_h;
    logic [SW-1:0] seq_v;
    logic [SW-1:0] seq_d2;
    logic [SW-1:0] seq_d3;
    logic          pal_h;
    logic          pal_v;
    logic          pal_d2;
    logic          pal_d3;
    logic          rows_ok;
    logic          left_ok;
    logic          right_ok;
    logic [gpc_pkg::FOUND_W-1:0] found;

    gpc_pkg::store_ctrl_t store_ctrl;
    gpc_pkg::tally_ctrl_t tally_ctrl;
    logic [CW-1:0]        wr_addr;
    logic [EW-1:0]        wr_data;
    logic [EW-1:0]        tail_data;
    logic                 tally_busy;
    logic [gpc_pkg::PAL_COUNT_W-1:0] out_count;

    // ---------------------------------------------------------------- config
    assign cfg_ready    = 1'b1;
    assign cols_restart = cfg_valid && (gpc_pkg::cfg_reg_t'(cfg_index) == gpc_pkg::REG_GRID_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_length_reg <= gpc_pkg::PAL_LENGTH_RST;
            grid_cols_reg  <= gpc_pkg::GRID_COLS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (gpc_pkg::cfg_reg_t'(cfg_index))
                gpc_pkg::REG_PAL_LENGTH: pal_length_reg <= cfg_data[gpc_pkg::PAL_LEN_W-1:0];
                gpc_pkg::REG_GRID_COLS:  grid_cols_reg  <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (pal_length_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (int'(pal_length_reg) > MAX_LEN)
        begin
            len_eff = LW'(MAX_LEN);
        end
        else
        begin
            len_eff = LW'(pal_length_reg);
        end
    end

    always_comb
    begin
        if (grid_cols_reg == '0)
        begin
            cols_eff = CNW'(1);
        end
        else if (int'(grid_cols_reg) > MAX_COLS)
        begin
            cols_eff = CNW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CNW'(grid_cols_reg);
        end
    end

    // ------------------------------------------------------------- front end
    assign s1_go         = s1_valid_reg && !(s1_last_reg && tally_busy);
    assign s_axis_tready = !s1_valid_reg || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign col_last      = (KW'(col_reg) + KW'(1)) >= KW'(cols_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rows_reg <= '0;
        end
        else if (cols_restart)
        begin
            col_reg  <= '0;
            rows_reg <= '0;
        end
        else if (in_acc)
        begin
            if (s_axis_tlast)
            begin
                col_reg  <= '0;
                rows_reg <= '0;
            end
            else if (col_last)
            begin
                col_reg <= '0;
                if (int'(rows_reg) < MAX_LEN - 1)
                begin
                    rows_reg <= rows_reg + RW'(1);
                end
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_letter_reg  <= s_axis_tdata;
            s1_last_reg    <= s_axis_tlast;
            s1_col_reg     <= col_reg;
            s1_rows_reg    <= rows_reg;
            s1_lastcol_reg <= col_last;
        end
    end

    // ---------------------------------------------------------- column store
    // Word at column c, read in row r, holds the row r-1 histories that end at
    // (c) going up, at (c+1) going up-right and at (c-1) going up-left.
    // The word for column c-1 is complete once cell c is known, so each cell
    // writes its left neighbor; the rightmost column goes to a tail register.
    assign store_ctrl.rd_en   = in_acc;
    assign store_ctrl.rd_tail = col_last;
    assign store_ctrl.wr_en   = s1_go && (s1_col_reg != '0);
    assign store_ctrl.tail_wr = s1_go && s1_lastcol_reg;
    assign wr_addr            = s1_col_reg - CW'(1);
    assign wr_data            = {d3_last2_reg, nd2, v_last_reg};
    assign tail_data          = {d3_last_reg, nd2, nv};

    gpc_col_store #(
        .DEPTH (MAX_COLS),
        .WIDTH (EW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (store_ctrl),
        .rd_addr   (col_reg),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .tail_data (tail_data),
        .rd_data   (prev_word)
    );

    // ------------------------------------------------------------ cell stage
    assign pv = prev_word[HW-1:0];
    assign p2 = prev_word[2*HW-1:HW];
    assign p3 = prev_word[3*HW-1:2*HW];

    // newest letter in the low byte; older cells above it
    assign seq_h  = SW'({h_reg, s1_letter_reg});
    assign seq_v  = SW'({pv, s1_letter_reg});
    assign seq_d2 = SW'({p2, s1_letter_reg});
    assign seq_d3 = SW'({p3, s1_letter_reg});
    assign h_next = HW'({h_reg, s1_letter_reg});
    assign nv     = HW'({pv, s1_letter_reg});
    assign nd2    = HW'({p2, s1_letter_reg});
    assign nd3    = HW'({p3, s1_letter_reg});

    gpc_pal_check #(.MAX_LEN(MAX_LEN)) u_chk_h  (.seq(seq_h),  .len(len_eff), .is_pal(pal_h));
    gpc_pal_check #(.MAX_LEN(MAX_LEN)) u_chk_v  (.seq(seq_v),  .len(len_eff), .is_pal(pal_v));
    gpc_pal_check #(.MAX_LEN(MAX_LEN)) u_chk_d2 (.seq(seq_d2), .len(len_eff), .is_pal(pal_d2));
    gpc_pal_check #(.MAX_LEN(MAX_LEN)) u_chk_d3 (.seq(seq_d3), .len(len_eff), .is_pal(pal_d3));

    assign rows_ok  = (KW'(s1_rows_reg) + KW'(1)) >= KW'(len_eff);
    assign left_ok  = (KW'(s1_col_reg) + KW'(1)) >= KW'(len_eff);
    assign right_ok = (KW'(s1_col_reg) + KW'(len_eff)) <= KW'(cols_eff);

    assign found = gpc_pkg::FOUND_W'(pal_h && left_ok)
                 + gpc_pkg::FOUND_W'(pal_v && rows_ok)
                 + gpc_pkg::FOUND_W'(pal_d2 && rows_ok && right_ok)
                 + gpc_pkg::FOUND_W'(pal_d3 && rows_ok && left_ok);

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            h_reg        <= h_next;
            v_last_reg   <= nv;
            d3_last_reg  <= nd3;
            d3_last2_reg <= d3_last_reg;
        end
    end

    // ----------------------------------------------------------------- total
    assign tally_ctrl.step    = s1_go;
    assign tally_ctrl.last    = s1_last_reg;
    assign tally_ctrl.restart = cols_restart;

    gpc_tally u_tally (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tally_ctrl),
        .found     (found),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_count (out_count),
        .busy      (tally_busy)
    );

    assign m_axis_tdata = {1'b0, out_count};

`ifndef SYNTHESIS
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        CNW'(col_reg) < cols_eff)
        else $error("column position outside the row");

    a_rows_sat: assert property (@(posedge clk) disable iff (!rst_n)
        int'(rows_reg) <= MAX_LEN - 1)
        else $error("row count beyond the held rows");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (col_reg == '0 && rows_reg == '0))
        else $error("grid position not restarted after last cell");
`endif

endmodule

FILE: hw/rtl/gpc_col_store.sv
// Per-column history memory with read forwarding and a register for the last column.
module gpc_col_store #(
    parameter int   DEPTH = gpc_pkg::MAX_COLS_DEF,
    parameter int   WIDTH = 3 * (gpc_pkg::MAX_LEN_DEF - 1) * gpc_pkg::LETTER_W,
    localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gpc_pkg::store_ctrl_t  ctrl,
    input  logic [AW-1:0]         rd_addr,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic [WIDTH-1:0]      tail_data,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] col_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic [WIDTH-1:0] tail_reg;
    logic             fwd_reg;
    logic             tail_sel_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            col_mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg    <= col_mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
        if (ctrl.tail_wr)
        begin
            tail_reg <= tail_data;
        end
    end

    // read and write of one entry in the same cycle: take the new word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg      <= 1'b0;
            tail_sel_reg <= 1'b0;
        end
        else if (ctrl.rd_en)
        begin
            fwd_reg      <= ctrl.wr_en && (wr_addr == rd_addr);
            tail_sel_reg <= ctrl.rd_tail;
        end
    end

    assign rd_data = tail_sel_reg ? tail_reg : (fwd_reg ? fwd_data_reg : rdata_reg);

endmodule

FILE: hw/rtl/gpc_pal_check.sv
// Palindrome test of a run of cells, run length chosen at run time.
module gpc_pal_check #(
    parameter int  MAX_LEN = gpc_pkg::MAX_LEN_DEF,
    localparam int LW      = $clog2(MAX_LEN + 1)
) (
    input  logic [MAX_LEN*gpc_pkg::LETTER_W-1:0] seq,
    input  logic [LW-1:0]                        len,
    output logic                                 is_pal
);

    localparam int BW = gpc_pkg::LETTER_W;

    logic [MAX_LEN:0] pal_by_len;

    always_comb
    begin
        logic ok;
        pal_by_len = '0;
        for (int l = 1; l <= MAX_LEN; l++)
        begin
            ok = 1'b1;
            for (int k = 0; k < l / 2; k++)
            begin
                ok = ok && (seq[BW*k +: BW] == seq[BW*(l-1-k) +: BW]);
            end
            pal_by_len[l] = ok;
        end
    end

    assign is_pal = pal_by_len[len];

endmodule

FILE: hw/rtl/gpc_tally.sv
// Saturating run total and the result output register.
module gpc_tally (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gpc_pkg::tally_ctrl_t              ctrl,
    input  logic [gpc_pkg::FOUND_W-1:0]       found,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [gpc_pkg::PAL_COUNT_W-1:0]   out_count,
    output logic                              busy
);

    logic [gpc_pkg::PAL_COUNT_W-1:0] total_reg;
    logic [gpc_pkg::PAL_COUNT_W-1:0] total_next;
    logic [gpc_pkg::PAL_COUNT_W-1:0] sum;
    logic [gpc_pkg::PAL_COUNT_W-1:0] count_reg;
    logic                            out_valid_reg;

    // the maximum plus four still fits the field width
    assign sum        = total_reg + gpc_pkg::PAL_COUNT_W'(found);
    assign total_next = (sum > gpc_pkg::PAL_COUNT_MAX) ? gpc_pkg::PAL_COUNT_MAX : sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.restart)
            begin
                total_reg <= '0;
            end
            else if (ctrl.step)
            begin
                total_reg <= ctrl.last ? '0 : total_next;
            end

            if (ctrl.step && ctrl.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step && ctrl.last)
        begin
            count_reg <= total_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_count = count_reg;
    assign busy      = out_valid_reg && !out_ready;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for grid_palindrome_counter_core: directed grids, then random grids.
module testbench;

    localparam int      HALF_PERIOD  = 6;
    localparam int      CFG_PAUSE    = 4;
    localparam int      DRAIN_CYCLES = 8;
    localparam int      RAND_CELLS   = 800;
    localparam int      RAND_COUNTS  = 40;
    localparam int      HOLD_CYCLES  = 300;
    localparam int      NUM_ROWS     = 24;
    localparam longint  RUN_LIMIT    = 64'd6_000_000;
    localparam int      STORE_DEPTH  = gpc_pkg::MAX_LEN_DEF * gpc_pkg::MAX_COLS_DEF;

    typedef enum logic { ROW_WRITE, ROW_CELLS } row_kind_t;
    typedef enum logic [1:0] { FILL_CONST, FILL_RAMP, FILL_PAIR } fill_t;

    // one directed step: a register write, or a run of cells
    typedef struct packed {
        row_kind_t                       kind;
        gpc_pkg::cfg_reg_t               reg_idx;
        logic [gpc_pkg::GRID_COLS_W-1:0] reg_val;
        logic [20:0]                     ncells;
        fill_t                           fill;
        logic [7:0]                      base;
        logic                            ends;       // last cell carries tlast
        logic                            typed;      // exp_count holds the expected total
        logic [gpc_pkg::PAL_COUNT_W-1:0] exp_count;
        logic                            burst;      // no sender gaps
    } dir_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [23:0]                     m_axis_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gpc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [gpc_pkg::GRID_COLS_W-1:0] cfg_data;

    // predictor state
    logic [7:0]                      grid_store [0:STORE_DEPTH-1];
    int                              col_pos;
    int                              rows_held;
    int                              slot;
    int unsigned                     total;
    logic [gpc_pkg::PAL_LEN_W-1:0]   len_reg;
    logic [gpc_pkg::GRID_COLS_W-1:0] cols_reg;

    logic [gpc_pkg::PAL_COUNT_W-1:0] count_q [$];
    dir_row_t                        dir_table [0:NUM_ROWS-1];
    int                              mismatches;
    int                              counts_seen;
    int                              cells_sent;
    int                              counts_pushed;

    grid_palindrome_counter_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    function automatic int run_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > gpc_pkg::MAX_LEN_DEF)
            return gpc_pkg::MAX_LEN_DEF;
        return int'(len_reg);
    endfunction

    function automatic int row_width();
        if (cols_reg == 0)
            return 1;
        if (cols_reg > gpc_pkg::MAX_COLS_DEF)
            return gpc_pkg::MAX_COLS_DEF;
        return int'(cols_reg);
    endfunction

    function automatic void restart_grid();
        col_pos   = 0;
        rows_held = 0;
        total     = 0;
        slot      = 0;
    endfunction

    function automatic void apply_reg(gpc_pkg::cfg_reg_t idx,
                                      logic [gpc_pkg::GRID_COLS_W-1:0] val);
        if (idx == gpc_pkg::REG_PAL_LENGTH)
            len_reg = val[gpc_pkg::PAL_LEN_W-1:0];
        else
        begin
            cols_reg = val;
            restart_grid();
        end
    endfunction

    // run ending at the current cell; step k goes back k*rstep rows and moves k*cstep columns
    function automatic int line_matches(int len, int cols, int rstep, int cstep);
        logic [7:0] seq [0:gpc_pkg::MAX_LEN_DEF-1];
        int         c;
        int         back;
        int         s;
        if (rstep != 0 && rows_held + 1 < len)
            return 0;
        for (int k = 0; k < len; k++)
        begin
            c    = col_pos + k * cstep;
            back = (rstep != 0) ? k : 0;
            if (c < 0 || c >= cols)
                return 0;
            s      = (slot + gpc_pkg::MAX_LEN_DEF - back) % gpc_pkg::MAX_LEN_DEF;
            seq[k] = grid_store[s * gpc_pkg::MAX_COLS_DEF + c];
        end
        for (int k = 0; k < len / 2; k++)
            if (seq[k] != seq[len - 1 - k])
                return 0;
        return 1;
    endfunction

    // advances the grid by one cell; returns 1 when a total is due
    function automatic bit tally_cell(logic [7:0] letter, logic last_cell,
                                      output logic [gpc_pkg::PAL_COUNT_W-1:0] cnt);
        int len;
        int cols;
        int found;
        len  = run_len();
        cols = row_width();
        cnt  = '0;
        if (col_pos >= cols)
            col_pos = cols - 1;
        grid_store[slot * gpc_pkg::MAX_COLS_DEF + col_pos] = letter;
        found = line_matches(len, cols, 0, -1) + line_matches(len, cols, 1, 0)
              + line_matches(len, cols, 1, 1) + line_matches(len, cols, 1, -1);
        total = total + found;
        if (total > gpc_pkg::PAL_COUNT_MAX)
            total = gpc_pkg::PAL_COUNT_MAX;
        if (last_cell)
        begin
            cnt = total[gpc_pkg::PAL_COUNT_W-1:0];
            restart_grid();
            return 1'b1;
        end
        col_pos++;
        if (col_pos >= cols)
        begin
            col_pos = 0;
            slot    = (slot + 1) % gpc_pkg::MAX_LEN_DEF;
            if (rows_held < gpc_pkg::MAX_LEN_DEF - 1)
                rows_held++;
        end
        return 1'b0;
    endfunction

    task automatic send_cell(logic [7:0] letter, logic last_cell, bit burst, bit typed,
                             logic [gpc_pkg::PAL_COUNT_W-1:0] typed_val);
        int                              gap;
        logic [gpc_pkg::PAL_COUNT_W-1:0] cnt;
        gap = burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= letter;
        s_axis_tlast  <= last_cell;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        if (tally_cell(letter, last_cell, cnt))
        begin
            count_q.push_back(typed ? typed_val : cnt);
            counts_pushed++;
        end
        cells_sent++;
    endtask

    // stop the input stream, wait for every pending total, then let the block settle
    task automatic drain_counts(int extra);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (count_q.size() != 0)
            @(posedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(gpc_pkg::cfg_reg_t idx, logic [gpc_pkg::GRID_COLS_W-1:0] val);
        drain_counts(CFG_PAUSE);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial
    begin
        int  gap;
        bit  rx_eager;
        logic [gpc_pkg::PAL_COUNT_W-1:0] want;
        m_axis_tready = 1'b0;
        counts_seen   = 0;
        rx_eager      = 1'b0;
        wait (rst_n === 1'b1);
        // long hold-off after reset: the first grids back up and stall the input
        repeat (HOLD_CYCLES) @(negedge clk);
        m_axis_tready <= 1'b1;
        forever
        begin
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
            if (count_q.size() == 0)
            begin
                $display("%0t: unexpected pal_count beat, expected none, got %0d",
                         $time, m_axis_tdata[gpc_pkg::PAL_COUNT_W-1:0]);
                mismatches++;
            end
            else
            begin
                want = count_q.pop_front();
                if (m_axis_tdata[gpc_pkg::PAL_COUNT_W-1:0] !== want)
                begin
                    $display("%0t: pal_count mismatch, expected %0d, got %0d",
                             $time, want, m_axis_tdata[gpc_pkg::PAL_COUNT_W-1:0]);
                    mismatches++;
                end
            end
            counts_seen++;
            if (counts_seen % 16 == 0)
                rx_eager = ($urandom_range(0, 2) == 0);
            gap = rx_eager ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        dir_row_t       step_row;
        logic [7:0]     letter;
        logic [7:0]     alpha [0:2];
        int             i;
        int             n;
        int             g;
        int             n_grids;
        int             size;
        int             width;
        int             kind_sel;
        bit             burst;
        bit             open_grid;
        int unsigned    cols;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = gpc_pkg::REG_PAL_LENGTH;
        cfg_data      = '0;
        mismatches    = 0;
        cells_sent    = 0;
        counts_pushed = 0;
        for (i = 0; i < STORE_DEPTH; i++)
            grid_store[i] = '0;
        len_reg  = gpc_pkg::PAL_LENGTH_RST;
        cols_reg = gpc_pkg::GRID_COLS_RST;
        restart_grid();

        //                kind       reg                      val      cells     fill
        //                base   ends  typed exp     burst
        dir_table[0]  = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd1,    FILL_CONST,
                          8'h00, 1'b1, 1'b1, 23'd4,  1'b0};
        dir_table[1]  = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd5,    FILL_CONST,
                          8'hFF, 1'b1, 1'b1, 23'd20, 1'b0};
        dir_table[2]  = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd2,    FILL_CONST,
                          8'h11, 1'b1, 1'b1, 23'd8,  1'b0};
        // length zero acts as one, on a grid of one column
        dir_table[3]  = '{ROW_WRITE, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[4]  = '{ROW_WRITE, gpc_pkg::REG_GRID_COLS,  11'd1,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[5]  = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd3,    FILL_CONST,
                          8'h55, 1'b1, 1'b1, 23'd12, 1'b0};
        dir_table[6]  = '{ROW_WRITE, gpc_pkg::REG_PAL_LENGTH, 11'd7,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[7]  = '{ROW_WRITE, gpc_pkg::REG_GRID_COLS,  11'd0,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        // one column, length clamped to six: only vertical runs from the sixth row on
        dir_table[8]  = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd8,    FILL_CONST,
                          8'hAA, 1'b1, 1'b1, 23'd3,  1'b0};
        dir_table[9]  = '{ROW_WRITE, gpc_pkg::REG_GRID_COLS,  11'd2047, 21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[10] = '{ROW_WRITE, gpc_pkg::REG_PAL_LENGTH, 11'd2,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[11] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd100,  FILL_RAMP,
                          8'h00, 1'b1, 1'b0, 23'd0,  1'b1};
        dir_table[12] = '{ROW_WRITE, gpc_pkg::REG_GRID_COLS,  11'd3,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[13] = '{ROW_WRITE, gpc_pkg::REG_PAL_LENGTH, 11'd3,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        // partial last row
        dir_table[14] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd7,    FILL_PAIR,
                          8'h0F, 1'b1, 1'b0, 23'd0,  1'b0};
        // length change in the middle of a grid
        dir_table[15] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd5,    FILL_PAIR,
                          8'hF0, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[16] = '{ROW_WRITE, gpc_pkg::REG_PAL_LENGTH, 11'd2,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[17] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd6,    FILL_PAIR,
                          8'h3C, 1'b1, 1'b0, 23'd0,  1'b0};
        // column write in the middle of a grid restarts it
        dir_table[18] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd4,    FILL_PAIR,
                          8'h99, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[19] = '{ROW_WRITE, gpc_pkg::REG_GRID_COLS,  11'd4,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[20] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd9,    FILL_PAIR,
                          8'hC3, 1'b1, 1'b0, 23'd0,  1'b0};
        dir_table[21] = '{ROW_WRITE, gpc_pkg::REG_PAL_LENGTH, 11'd6,    21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        dir_table[22] = '{ROW_WRITE, gpc_pkg::REG_GRID_COLS,  11'd30,   21'd0,    FILL_CONST,
                          8'h00, 1'b0, 1'b0, 23'd0,  1'b0};
        // several full rows: row history wraps around
        dir_table[23] = '{ROW_CELLS, gpc_pkg::REG_PAL_LENGTH, 11'd0,    21'd200,  FILL_CONST,
                          8'h41, 1'b1, 1'b0, 23'd0,  1'b1};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < NUM_ROWS; i++)
        begin
            step_row = dir_table[i];
            if (step_row.kind == ROW_WRITE)
                write_reg(step_row.reg_idx, step_row.reg_val);
            else
                for (n = 0; n < int'(step_row.ncells); n++)
                begin
                    case (step_row.fill)
                        FILL_RAMP: letter = step_row.base + n[7:0];
                        FILL_PAIR: letter = $urandom_range(0, 1) ? step_row.base : ~step_row.base;
                        default:   letter = step_row.base;
                    endcase
                    send_cell(letter, step_row.ends && (n == int'(step_row.ncells) - 1),
                              step_row.burst, step_row.typed, step_row.exp_count);
                end
        end

        cells_sent    = 0;
        counts_pushed = 0;
        while (cells_sent < RAND_CELLS || counts_pushed < RAND_COUNTS)
        begin
            // upper data bits are junk for the length register
            write_reg(gpc_pkg::REG_PAL_LENGTH,
                      gpc_pkg::GRID_COLS_W'(($urandom_range(0, 255) << gpc_pkg::PAL_LEN_W)
                                            | $urandom_range(0, 7)));
            if ($urandom_range(0, 3) != 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    cols = $urandom_range(0, 2047);
                else
                    cols = $urandom_range(1, 8);
                write_reg(gpc_pkg::REG_GRID_COLS, gpc_pkg::GRID_COLS_W'(cols));
            end
            width   = row_width();
            n_grids = $urandom_range(1, 4);
            for (g = 0; g < n_grids; g++)
            begin
                size = width * $urandom_range(1, 7) + $urandom_range(0, width - 1);
                if (size > 60)
                    size = $urandom_range(1, 60);
                kind_sel  = $urandom_range(0, 3);
                alpha[0]  = $urandom_range(0, 255);
                alpha[1]  = $urandom_range(0, 255);
                alpha[2]  = $urandom_range(0, 255);
                burst     = ($urandom_range(0, 3) == 0);
                // sometimes leave the grid open across the next register write
                open_grid = (g == n_grids - 1) && ($urandom_range(0, 3) == 0);
                for (n = 0; n < size; n++)
                begin
                    case (kind_sel)
                        0:       letter = $urandom_range(0, 255);
                        1:       letter = alpha[$urandom_range(0, 1)];
                        default: letter = alpha[$urandom_range(0, 2)];
                    endcase
                    send_cell(letter, !open_grid && (n == size - 1), burst, 1'b0, '0);
                end
            end
        end

        drain_counts(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
